### src/alkm_pkg.sv
package alkm_pkg;

    localparam int KIND_W = 6;
    localparam int FIELD_W = 16;
    localparam int NUM_KW = 37;
    localparam int NUM_PUNCT = 8;
    localparam int KW_MAX_CHARS = 8;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_LABEL,
        MODE_COMMENT,
        MODE_SLASH
    } mode_t;

    localparam logic [KIND_W-1:0] KIND_LABEL = 6'd8;
    localparam logic [KIND_W-1:0] KIND_NUM = 6'd9;
    localparam logic [KIND_W-1:0] KIND_ID = 6'd10;
    localparam logic [KIND_W-1:0] KIND_KW0 = 6'd11;
    localparam logic [KIND_W-1:0] KIND_END = 6'd48;

    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [7:0] PUNCT [NUM_PUNCT] = '{
        8'h3D, 8'h2B, 8'h2D, 8'h21, 8'h26, 8'h7C, 8'h40, 8'h3B
    };

    localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [NUM_KW] = '{
        "r0", "r1", "r2", "r3", "r4", "r5", "r6", "r7", "r8", "r9",
        "r10", "r11", "r12", "r13", "r14", "r15",
        "sp", "lcl", "arg", "this", "that", "screen", "kbd",
        "jgt", "jge", "jlt", "jle", "jne", "jeq", "jmp",
        "a", "d", "m", "ad", "am", "md", "amd"
    };

    localparam logic [3:0] KW_LEN [NUM_KW] = '{
        4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2, 4'd2,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd2, 4'd3, 4'd3, 4'd4, 4'd4, 4'd6, 4'd3,
        4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3,
        4'd1, 4'd1, 4'd1, 4'd2, 4'd2, 4'd2, 4'd3
    };

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] length;
        logic [FIELD_W-1:0] line;
        logic               last;
    } token_t;

    function automatic logic [7:0] kw_byte(input int k, input int i);
        logic [8*KW_MAX_CHARS-1:0] text;
        int len;
        text = KW_TEXT[k];
        len = int'(KW_LEN[k]);
        if (i < len)
            return text[8*(len-1-i) +: 8];
        else
            return 8'h00;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
               (c == CH_UNDER) || is_digit(c);
    endfunction

endpackage

### src/alkm_char_if.sv
interface alkm_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink (input valid, input ch, output ready);
endinterface

### src/alkm_token_if.sv
interface alkm_token_if;
    logic        valid;
    logic        ready;
    logic [5:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output token_line, output last, input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input token_line, input last, output ready);
endinterface

### src/assembly_lexer_keyword_match_core.sv
// Streaming lexer for Hack-style assembly: one character item in, zero to two token items
// out. The scan state updates in the cycle a character is accepted and its tokens enter a
// four-entry output queue, so a character is taken every cycle while the queue has two free
// entries. The output side drains one token per cycle while ready is high; a character
// that ends a word and is itself punctuation or end of text makes two tokens, word first.
// A 0 character emits the end-of-text token and restarts at offset 0, line 1.
module assembly_lexer_keyword_match_core #(
    parameter int COUNT_BITS = 16,
    parameter int KEYWORD_CHARS = 6
) (
    input  logic         clk,
    input  logic         rst_n,
    alkm_char_if.sink    chars,
    alkm_token_if.source tokens
);
    import alkm_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    mode_t                  mode_reg, mode_next;
    logic [COUNT_BITS-1:0]  pos_reg, pos_next;
    logic [COUNT_BITS-1:0]  start_reg, start_next;
    logic [COUNT_BITS-1:0]  len_reg, len_next;
    logic [COUNT_BITS-1:0]  line_reg, line_next;
    logic                   dig_reg, dig_next;
    logic [7:0]             wc_reg [KEYWORD_CHARS];
    logic [7:0]             wc_next [KEYWORD_CHARS];

    token_t                 q_reg [QDEPTH];
    logic [QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]        cnt_reg, cnt_next;

    logic                   accept;
    logic                   pop;
    token_t                 tok0, tok1, word_tok, idle_tok;
    logic [1:0]             tok_cnt;
    logic                   ended;
    logic                   do_idle;
    logic                   idle_have;
    logic                   kw_hit;
    logic [KIND_W-1:0]      kw_idx;
    logic                   kw_match;
    logic                   p_hit;
    logic [2:0]             p_idx;
    logic [7:0]             c;

    assign c = chars.ch;
    assign accept = chars.valid && chars.ready;
    assign pop = tokens.valid && tokens.ready;
    assign chars.ready = (cnt_reg <= (QPTR_W+1)'(QDEPTH - 2));

    assign tokens.valid = (cnt_reg != '0);
    assign tokens.token_kind = q_reg[rd_ptr_reg].kind;
    assign tokens.token_start = q_reg[rd_ptr_reg].start;
    assign tokens.token_length = q_reg[rd_ptr_reg].length;
    assign tokens.token_line = q_reg[rd_ptr_reg].line;
    assign tokens.last = q_reg[rd_ptr_reg].last;

    always_comb
    begin
        kw_hit = 1'b0;
        kw_idx = '0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            kw_match = (len_reg == COUNT_BITS'(KW_LEN[k])) && (KW_LEN[k] <= KEYWORD_CHARS);
            for (int i = 0; i < KEYWORD_CHARS; i++)
            begin
                if ((i < int'(KW_LEN[k])) && (wc_reg[i] != kw_byte(k, i)))
                    kw_match = 1'b0;
            end
            if (kw_match && !kw_hit)
            begin
                kw_hit = 1'b1;
                kw_idx = KIND_W'(k);
            end
        end
        word_tok.kind = kw_hit ? (KIND_KW0 + kw_idx) : (dig_reg ? KIND_NUM : KIND_ID);
        word_tok.start = FIELD_W'(start_reg);
        word_tok.length = FIELD_W'(len_reg);
        word_tok.line = FIELD_W'(line_reg);
        word_tok.last = 1'b0;

        p_hit = 1'b0;
        p_idx = '0;
        for (int k = 0; k < NUM_PUNCT; k++)
        begin
            if ((c == PUNCT[k]) && !p_hit)
            begin
                p_hit = 1'b1;
                p_idx = 3'(k);
            end
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        pos_next = pos_reg;
        start_next = start_reg;
        len_next = len_reg;
        line_next = line_reg;
        dig_next = dig_reg;
        wc_next = wc_reg;
        tok0 = '0;
        tok1 = '0;
        tok_cnt = 2'd0;
        ended = 1'b0;
        do_idle = 1'b0;
        idle_have = 1'b0;
        idle_tok = '0;

        unique case (mode_reg)
            MODE_WORD:
            begin
                if (is_word_char(c))
                begin
                    for (int i = 0; i < KEYWORD_CHARS; i++)
                    begin
                        if (len_reg == COUNT_BITS'(i))
                            wc_next[i] = c;
                    end
                    len_next = (len_reg == '1) ? len_reg : len_reg + 1'b1;
                    dig_next = dig_reg && is_digit(c);
                end
                else
                begin
                    tok0 = word_tok;
                    tok_cnt = 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_LABEL:
            begin
                if (c == CH_NUL)
                    do_idle = 1'b1;
                else if (c == CH_RPAREN)
                begin
                    tok0.kind = KIND_LABEL;
                    tok0.start = FIELD_W'(start_reg);
                    tok0.length = FIELD_W'(len_reg);
                    tok0.line = FIELD_W'(line_reg);
                    tok_cnt = 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                    len_next = (len_reg == '1) ? len_reg : len_reg + 1'b1;
            end
            MODE_COMMENT:
            begin
                if (c == CH_NUL)
                    do_idle = 1'b1;
                else if (c == CH_NL)
                begin
                    line_next = (line_reg == '1) ? line_reg : line_reg + 1'b1;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    mode_next = MODE_COMMENT;
                else
                    do_idle = 1'b1;
            end
            default:
                do_idle = 1'b1;
        endcase

        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            idle_tok.start = FIELD_W'(pos_reg);
            idle_tok.line = FIELD_W'(line_reg);
            if (c == CH_NUL)
            begin
                idle_tok.kind = KIND_END;
                idle_have = 1'b1;
                ended = 1'b1;
            end
            else if (p_hit)
            begin
                idle_tok.kind = KIND_W'(p_idx);
                idle_tok.length = FIELD_W'(1);
                idle_have = 1'b1;
            end
            else if (c == CH_LPAREN)
            begin
                mode_next = MODE_LABEL;
                start_next = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
                len_next = '0;
            end
            else if (c == CH_SLASH)
                mode_next = MODE_SLASH;
            else if (c == CH_NL)
                line_next = (line_reg == '1) ? line_reg : line_reg + 1'b1;
            else if (is_word_char(c))
            begin
                mode_next = MODE_WORD;
                start_next = pos_reg;
                len_next = COUNT_BITS'(1);
                wc_next[0] = c;
                dig_next = is_digit(c);
            end

            if (idle_have)
            begin
                if (tok_cnt == 2'd0)
                    tok0 = idle_tok;
                else
                    tok1 = idle_tok;
                tok_cnt = tok_cnt + 2'd1;
            end
        end

        if (tok_cnt == 2'd1)
            tok0.last = 1'b1;
        if (tok_cnt == 2'd2)
            tok1.last = 1'b1;

        if (ended)
        begin
            mode_next = MODE_IDLE;
            pos_next = '0;
            start_next = '0;
            len_next = '0;
            line_next = COUNT_BITS'(1);
            dig_next = 1'b1;
        end
        else
            pos_next = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (accept)
            cnt_next = cnt_next + (QPTR_W+1)'(tok_cnt);
        if (pop)
            cnt_next = cnt_next - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            pos_reg <= '0;
            start_reg <= '0;
            len_reg <= '0;
            line_reg <= COUNT_BITS'(1);
            dig_reg <= 1'b1;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                pos_reg <= pos_next;
                start_reg <= start_next;
                len_reg <= len_next;
                line_reg <= line_next;
                dig_reg <= dig_next;
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(tok_cnt);
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wc_reg <= wc_next;
            if (tok_cnt != 2'd0)
                q_reg[wr_ptr_reg] <= tok0;
            if (tok_cnt == 2'd2)
                q_reg[wr_ptr_reg + 1'b1] <= tok1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (QPTR_W+1)'(QDEPTH))
    else $error("token queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (c == CH_NUL)) |=> (mode_reg == MODE_IDLE) && (pos_reg == '0))
    else $error("end of text did not restart the scanner");

    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
    else $error("line count reached zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (c == CH_NUL)) |-> (tok_cnt != 2'd0))
    else $error("end of text produced no token");
endmodule

### bench/assembly_lexer_keyword_match_core_tb.sv
`timescale 1ns / 100ps

module assembly_lexer_keyword_match_core_tb;

    import alkm_pkg::*;

    localparam int WORD_KEEP = 6;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_CHARS = 660;
    localparam int CALM_CHARS = 200;
    localparam int LONG_RUN = 20;
    localparam int LONG_STALL = 300;

    logic clk = 1'b0;
    logic rst_n;

    alkm_char_if  chars_bus ();
    alkm_token_if tokens_bus ();

    assembly_lexer_keyword_match_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .chars  (chars_bus),
        .tokens (tokens_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    string kw_names [NUM_KW] = '{
        "r0", "r1", "r2", "r3", "r4", "r5", "r6", "r7", "r8", "r9",
        "r10", "r11", "r12", "r13", "r14", "r15",
        "sp", "lcl", "arg", "this", "that", "screen", "kbd",
        "jgt", "jge", "jlt", "jle", "jne", "jeq", "jmp",
        "a", "d", "m", "ad", "am", "md", "amd"
    };
    string punct_marks = "=+-!&|@;";

    // lexer shadow state
    mode_t       scan_state;
    logic [15:0] char_pos;
    logic [15:0] word_start;
    logic [15:0] word_len;
    logic [15:0] line_no;
    logic [7:0]  word_buf [WORD_KEEP];
    logic        only_digits;

    token_t      step_tokens [$];
    token_t      pending_tokens [$];
    logic [7:0]  char_buf [$];

    int  error_count = 0;
    int  tokens_checked = 0;
    int  chars_sent = 0;
    int  texts_ended = 0;
    int  idle_cycles = 0;
    int  stall_cycles = 0;
    bit  sender_gaps = 1'b1;
    bit  receiver_gaps = 1'b1;

    function automatic logic [15:0] bump(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic bit char_is_digit(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic bit char_in_word(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CH_UNDER};
    endfunction

    function automatic int punct_kind(input logic [7:0] c);
        for (int k = 0; k < NUM_PUNCT; k++)
            if (punct_marks[k] == c)
                return k;
        return -1;
    endfunction

    function automatic void clear_lexer();
        scan_state = MODE_IDLE;
        char_pos = '0;
        word_start = '0;
        word_len = '0;
        line_no = 16'd1;
        only_digits = 1'b1;
        foreach (word_buf[i])
            word_buf[i] = 8'h00;
    endfunction

    function automatic void add_token(input logic [5:0] kind, input logic [15:0] start,
                                      input logic [15:0] len, input logic [15:0] at_line);
        token_t t;
        t.kind = kind;
        t.start = start;
        t.length = len;
        t.line = at_line;
        t.last = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic logic [5:0] word_kind();
        bit same;
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (kw_names[k].len() == word_len)
            begin
                same = 1'b1;
                for (int i = 0; i < kw_names[k].len(); i++)
                    if (kw_names[k][i] != word_buf[i])
                        same = 1'b0;
                if (same)
                    return KIND_KW0 + 6'(k);
            end
        end
        return only_digits ? KIND_NUM : KIND_ID;
    endfunction

    function automatic bit lex_from_idle(input logic [7:0] c);
        int p;
        p = punct_kind(c);
        scan_state = MODE_IDLE;
        if (c == CH_NUL)
        begin
            add_token(KIND_END, char_pos, 16'd0, line_no);
            return 1'b1;
        end
        if (p >= 0)
            add_token(6'(p), char_pos, 16'd1, line_no);
        else if (c == CH_LPAREN)
        begin
            scan_state = MODE_LABEL;
            word_start = bump(char_pos);
            word_len = '0;
        end
        else if (c == CH_SLASH)
            scan_state = MODE_SLASH;
        else if (c == CH_NL)
            line_no = bump(line_no);
        else if (char_in_word(c))
        begin
            scan_state = MODE_WORD;
            word_start = char_pos;
            word_len = 16'd1;
            word_buf[0] = c;
            only_digits = char_is_digit(c);
        end
        return 1'b0;
    endfunction

    function automatic void lex_char(input logic [7:0] c);
        bit ended;
        ended = 1'b0;
        step_tokens.delete();
        case (scan_state)
            MODE_WORD:
                if (char_in_word(c))
                begin
                    if (word_len < WORD_KEEP)
                        word_buf[word_len] = c;
                    word_len = bump(word_len);
                    only_digits = only_digits && char_is_digit(c);
                end
                else
                begin
                    add_token(word_kind(), word_start, word_len, line_no);
                    ended = lex_from_idle(c);
                end
            MODE_LABEL:
                if (c == CH_NUL)
                    ended = lex_from_idle(c);
                else if (c == CH_RPAREN)
                begin
                    add_token(KIND_LABEL, word_start, word_len, line_no);
                    scan_state = MODE_IDLE;
                end
                else
                    word_len = bump(word_len);
            MODE_COMMENT:
                if (c == CH_NUL)
                    ended = lex_from_idle(c);
                else if (c == CH_NL)
                begin
                    line_no = bump(line_no);
                    scan_state = MODE_IDLE;
                end
            MODE_SLASH:
                if (c == CH_SLASH)
                    scan_state = MODE_COMMENT;
                else
                    ended = lex_from_idle(c);
            default:
                ended = lex_from_idle(c);
        endcase
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            pending_tokens.push_back(step_tokens[i]);
        if (ended)
            clear_lexer();
        else
            char_pos = bump(char_pos);
    endfunction

    function automatic void compare_field(input string field, input int unsigned want,
                                          input int unsigned got);
        if (want != got)
        begin
            $display("%0t ns: token %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
            error_count++;
        end
    endfunction

    // token checker and watchdog
    always @(posedge clk)
    begin
        token_t want;
        if (rst_n === 1'b1)
        begin
            if ((chars_bus.valid && chars_bus.ready) || (tokens_bus.valid && tokens_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (tokens_bus.valid && tokens_bus.ready)
            begin
                if (pending_tokens.size() == 0)
                begin
                    $display("%0t ns: unexpected token, expected none, actual kind %0d start %0d",
                             $time, tokens_bus.token_kind, tokens_bus.token_start);
                    error_count++;
                end
                else
                begin
                    want = pending_tokens.pop_front();
                    compare_field("kind", want.kind, tokens_bus.token_kind);
                    compare_field("start", want.start, tokens_bus.token_start);
                    compare_field("length", want.length, tokens_bus.token_length);
                    compare_field("line", want.line, tokens_bus.token_line);
                    compare_field("last", want.last, tokens_bus.last);
                    tokens_checked++;
                end
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles, %0d tokens outstanding",
                         $time, idle_cycles, pending_tokens.size());
                $display("assembly_lexer_keyword_match_core_tb: errors");
                $finish;
            end
        end
    end

    // token receiver
    initial
    begin
        int pause;
        tokens_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (stall_cycles > 0)
            begin
                pause = stall_cycles;
                stall_cycles = 0;
            end
            else
                pause = receiver_gaps ? $urandom_range(0, 9) : 0;
            if (pause > 0)
            begin
                tokens_bus.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            tokens_bus.ready <= 1'b1;
            @(posedge clk);
            while (!tokens_bus.valid)
                @(posedge clk);
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            chars_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_bus.valid <= 1'b1;
        chars_bus.ch <= c;
        @(posedge clk);
        while (!chars_bus.ready)
            @(posedge clk);
        lex_char(c);
        chars_sent++;
        if (c == CH_NUL)
            texts_ended++;
    endtask

    task automatic send_buffer();
        while (char_buf.size() > 0)
            send_char(char_buf.pop_front());
    endtask

    task automatic wait_drained();
        chars_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            char_buf.push_back(s[i]);
    endfunction

    function automatic logic [7:0] rand_word_char();
        case ($urandom_range(0, 3))
            0: return 8'h61 + 8'($urandom_range(0, 25));
            1: return 8'h41 + 8'($urandom_range(0, 25));
            2: return 8'h30 + 8'($urandom_range(0, 9));
            default: return CH_UNDER;
        endcase
    endfunction

    function automatic void put_word();
        string kw;
        int n;
        logic [7:0] c;
        kw = kw_names[$urandom_range(0, NUM_KW - 1)];
        case ($urandom_range(0, 6))
            0, 1: put_str(kw);
            2:
            begin
                n = $urandom_range(0, kw.len() - 1);
                for (int i = 0; i < kw.len(); i++)
                begin
                    c = kw[i];
                    if (i == n && c inside {[8'h61:8'h7A]})
                        c = c - 8'd32;
                    char_buf.push_back(c);
                end
            end
            3:
            begin
                put_str(kw);
                char_buf.push_back(rand_word_char());
            end
            4:
            begin
                n = $urandom_range(1, 7);
                repeat (n) char_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
            end
            5: put_str(kw.substr(0, $urandom_range(0, kw.len() - 1)));
            default:
            begin
                n = $urandom_range(1, 10);
                repeat (n) char_buf.push_back(rand_word_char());
            end
        endcase
    endfunction

    function automatic void put_fragment();
        int n;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                put_str("@");
                put_word();
                put_str("\n");
            end
            2, 3:
            begin
                put_word();
                put_str("=");
                put_word();
                if ($urandom_range(0, 1))
                begin
                    char_buf.push_back(punct_marks[$urandom_range(0, 5)]);
                    put_word();
                end
                if ($urandom_range(0, 1))
                begin
                    put_str(";");
                    put_word();
                end
                put_str("\n");
            end
            4:
            begin
                put_str("(");
                n = $urandom_range(0, 8);
                repeat (n)
                    case ($urandom_range(0, 3))
                        0: char_buf.push_back(CH_NL);
                        1: char_buf.push_back(8'($urandom_range(1, 255)));
                        default: char_buf.push_back(rand_word_char());
                    endcase
                put_str(")");
            end
            5:
            begin
                put_str("//");
                n = $urandom_range(0, 10);
                repeat (n) char_buf.push_back(8'($urandom_range(1, 255)));
                put_str("\n");
            end
            6:
            begin
                put_str("/");
                if ($urandom_range(0, 1))
                    char_buf.push_back(punct_marks[$urandom_range(0, NUM_PUNCT - 1)]);
                else
                    put_word();
            end
            7:
            begin
                n = $urandom_range(1, 3);
                repeat (n) char_buf.push_back(8'($urandom_range(1, 255)));
            end
            8:
                case ($urandom_range(0, 3))
                    0: put_str(" ");
                    1: put_str("\t");
                    2: char_buf.push_back(8'h0D);
                    default: put_str("\n");
                endcase
            default:
            begin
                put_word();
                put_str(" ");
            end
        endcase
    endfunction

    task automatic send_random_chars(input int count);
        int stop_at;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at)
        begin
            put_fragment();
            if ($urandom_range(0, 11) == 0)
                char_buf.push_back(CH_NUL);
            send_buffer();
        end
    endtask

    task automatic test_punctuation();
        put_str("=+-!&|@;");
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    task automatic test_keywords();
        foreach (kw_names[k])
        begin
            put_str(kw_names[k]);
            put_str(" ");
        end
        put_str("SCREEN screens Amd r16 007 _x9 A\tsp\n");
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    task automatic test_word_endings();
        put_str("amd=m+1;jmp!x&y|z@k(lbl)w/v q//c\nr5");
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    task automatic test_labels();
        put_str("(LOOP)\n(a\nb c)\n@LOOP\n()(open");
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    task automatic test_comments();
        put_str("// = @x\n@1 /=\n/\n//");
        char_buf.push_back(CH_NUL);
        put_str("/");
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    task automatic test_odd_bytes();
        char_buf.push_back(8'h01);
        char_buf.push_back(8'h80);
        char_buf.push_back(8'hFF);
        char_buf.push_back(8'h0D);
        put_str("#$~`@");
        char_buf.push_back(8'hAA);
        char_buf.push_back(8'h55);
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    // hold the token side off while characters keep coming
    task automatic test_output_stall();
        stall_cycles = LONG_STALL;
        repeat (16) put_str("ad=m;");
        char_buf.push_back(CH_NUL);
        sender_gaps = 1'b0;
        send_buffer();
        sender_gaps = 1'b1;
    endtask

    task automatic test_drained_pause();
        repeat (4) put_fragment();
        send_buffer();
        wait_drained();
        repeat (4) put_fragment();
        char_buf.push_back(CH_NUL);
        send_buffer();
    endtask

    task automatic test_no_idling();
        sender_gaps = 1'b0;
        receiver_gaps = 1'b0;
        send_random_chars(CALM_CHARS);
        sender_gaps = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task automatic test_random_text();
        send_random_chars(RANDOM_CHARS);
        send_char(CH_NUL);
    endtask

    // long label, long word past the kept characters and a run of newlines
    task automatic test_long_runs();
        sender_gaps = 1'b0;
        send_char(CH_LPAREN);
        repeat (LONG_RUN) send_char(8'h78);
        send_char(CH_RPAREN);
        repeat (LONG_RUN) send_char(8'h77);
        send_char(8'h20);
        repeat (LONG_RUN) send_char(CH_NL);
        put_str("(ab)@12");
        char_buf.push_back(CH_NUL);
        send_buffer();
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        chars_bus.valid <= 1'b0;
        chars_bus.ch <= CH_NUL;
        clear_lexer();
        wait (rst_n === 1'b1);
        @(posedge clk);

        test_punctuation();
        test_keywords();
        test_word_endings();
        test_labels();
        test_comments();
        test_odd_bytes();
        test_output_stall();
        test_drained_pause();
        test_no_idling();
        test_random_text();
        test_long_runs();

        wait_drained();
        repeat (8) @(posedge clk);
        $display("run covered %0d characters in %0d texts and checked %0d tokens,",
                 chars_sent, texts_ended, tokens_checked);
        $display("including every token kind, output back-pressure and long words and labels");
        if (error_count == 0)
            $display("assembly_lexer_keyword_match_core_tb: clean");
        else
            $display("assembly_lexer_keyword_match_core_tb: errors");
        $finish;
    end

endmodule

### files.f
src/alkm_pkg.sv
src/alkm_char_if.sv
src/alkm_token_if.sv
src/assembly_lexer_keyword_match_core.sv
bench/assembly_lexer_keyword_match_core_tb.sv
